### design/mfbp_pkg.sv
package mfbp_pkg;

    localparam int BYTE_BITS    = 8;
    localparam int MAX_PUT_BITS = 16;
    localparam int PEND_BITS    = 7;
    localparam int ACC_BITS     = PEND_BITS + MAX_PUT_BITS;   // 23
    localparam int CNT_BITS     = 5;                          // holds 0..23
    localparam int PCNT_BITS    = 3;                          // holds 0..7
    localparam int SH_BITS      = 4;                          // byte shift 0..15

    localparam logic MODE_PUT   = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;   // capture the accepted item into the accumulator
        logic emit;   // move the top byte into the output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic load_has_byte;  // the item being loaded completes at least one byte
        logic byte_is_last;   // the byte at the top of the accumulator is the last one
        logic out_free;       // the output register can take a byte this cycle
    } t_status;

endpackage

### design/mfbp_datapath.sv
module mfbp_datapath
    import mfbp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    input  logic                  i_mode,
    input  logic [15:0]           i_value_bits,
    input  logic [4:0]            i_bit_count,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output logic [7:0]            o_out_byte,
    output logic                  o_last_of_run
);

    logic [PEND_BITS-1:0] r_pend_val, n_pend_val;
    logic [PCNT_BITS-1:0] r_pend_cnt, n_pend_cnt;
    logic [ACC_BITS-1:0]  r_acc, n_acc;
    logic [CNT_BITS-1:0]  r_cnt, n_cnt;
    logic                 r_out_valid;
    logic [7:0]           r_out_byte;
    logic                 r_out_last;

    logic [CNT_BITS-1:0]  w_len;
    logic [15:0]          w_val_mask;
    logic [ACC_BITS-1:0]  w_put_acc;
    logic [CNT_BITS-1:0]  w_put_cnt;
    logic [PEND_BITS-1:0] w_keep_mask;
    logic [7:0]           w_flush_byte;
    logic [CNT_BITS-1:0]  w_cnt_less;
    logic [SH_BITS-1:0]   w_sh;
    logic [7:0]           w_top_byte;

    // put path: saturate length, append masked bits behind the pending ones
    always_comb begin
        w_len       = (i_bit_count > CNT_BITS'(MAX_PUT_BITS)) ? CNT_BITS'(MAX_PUT_BITS)
                                                              : i_bit_count;
        w_val_mask  = 16'((17'(1) << w_len) - 17'(1));
        w_put_acc   = (ACC_BITS'(r_pend_val) << w_len) | ACC_BITS'(i_value_bits & w_val_mask);
        w_put_cnt   = CNT_BITS'(r_pend_cnt) + w_len;
        w_keep_mask = PEND_BITS'((8'(1) << w_put_cnt[PCNT_BITS-1:0]) - 8'(1));
    end

    // flush path: left-align pending bits in a byte, zero padded
    assign w_flush_byte = 8'({1'b0, r_pend_val} << (4'(BYTE_BITS) - {1'b0, r_pend_cnt}));

    // byte selection at the top of the accumulator
    always_comb begin
        w_cnt_less = r_cnt - CNT_BITS'(BYTE_BITS);
        w_sh       = w_cnt_less[SH_BITS-1:0];
        w_top_byte = 8'(r_acc >> w_sh);
    end

    // next state of accumulator and pending bits
    always_comb begin
        n_acc      = r_acc;
        n_cnt      = r_cnt;
        n_pend_val = r_pend_val;
        n_pend_cnt = r_pend_cnt;
        if (i_cmd.load) begin
            if (i_mode == MODE_FLUSH) begin
                n_acc      = ACC_BITS'(w_flush_byte);
                n_cnt      = (r_pend_cnt != '0) ? CNT_BITS'(BYTE_BITS) : '0;
                n_pend_val = '0;
                n_pend_cnt = '0;
            end else begin
                n_acc      = w_put_acc;
                n_cnt      = w_put_cnt;
                n_pend_val = w_put_acc[PEND_BITS-1:0] & w_keep_mask;
                n_pend_cnt = w_put_cnt[PCNT_BITS-1:0];
            end
        end else if (i_cmd.emit) begin
            n_cnt = w_cnt_less;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_val <= '0;
            r_pend_cnt <= '0;
            r_cnt      <= '0;
        end else begin
            r_pend_val <= n_pend_val;
            r_pend_cnt <= n_pend_cnt;
            r_cnt      <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_byte <= w_top_byte;
            r_out_last <= ~w_sh[SH_BITS-1];
        end
    end

    // status
    always_comb begin
        o_status.load_has_byte = (i_mode == MODE_FLUSH) ? (r_pend_cnt != '0)
                                                        : (w_put_cnt >= CNT_BITS'(BYTE_BITS));
        o_status.byte_is_last  = ~w_sh[SH_BITS-1];
        o_status.out_free      = ~r_out_valid | ~i_out_stall;
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_last_of_run = r_out_last;

endmodule

### design/mfbp_ctrl.sv
module mfbp_ctrl
    import mfbp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_status.load_has_byte) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_status.out_free && i_status.byte_is_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd.load = 1'b0;
        o_cmd.emit = 1'b0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            ST_EMIT: begin
                o_cmd.emit = i_status.out_free;
            end
            default: o_in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### design/msb_first_bit_packer_unit.sv
// MSB-first bit packer: put items append 0..16 bits, flush items pad to a byte.
// An accepted item is loaded into the accumulator, and its bytes then move into the
// single byte-wide output register fed from the accumulator, one per cycle while it is free;
// the input is stalled until the last byte of the item has been moved.
// Reset: synchronous active-low i_rst_n clears pending bits, controller and output valid.
module msb_first_bit_packer_unit
    import mfbp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_mode,
    input  logic [15:0] i_value_bits,
    input  logic [4:0]  i_bit_count,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_last_of_run
);

    t_cmd    w_cmd;
    t_status w_status;

    mfbp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    mfbp_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_mode        (i_mode),
        .i_value_bits  (i_value_bits),
        .i_bit_count   (i_bit_count),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run)
    );

endmodule

### sim/mfbp_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the bit packer, predicts the bytes of every
// accepted item and compares them, in order, with the bytes that leave.
module mfbp_checker
    import mfbp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic        i_mode,
    input  logic [15:0] i_value_bits,
    input  logic [4:0]  i_bit_count,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [7:0]  i_out_byte,
    input  logic        i_last_of_run,
    output int          o_fail_count,
    output int          o_bytes_left,
    output int          o_bytes_seen
);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_out_byte;

    t_out_byte             expected_bytes[$];
    logic [PEND_BITS-1:0]  held_bits;
    logic [PCNT_BITS-1:0]  held_count;
    int                    fail_total;
    int                    seen_total;

    // Appends the bytes one item completes and updates the held bits
    task automatic pack_item(input logic mode, input logic [15:0] value,
                             input logic [4:0] count);
        logic [ACC_BITS-1:0] acc;
        t_out_byte           b;
        int                  len;
        int                  total;
        int                  first;
        first = expected_bytes.size();
        if (mode == MODE_FLUSH) begin
            // pad held bits with zeros up to a whole byte
            if (held_count != 0) begin
                b.data = 8'({1'b0, held_bits} << (BYTE_BITS - int'(held_count)));
                b.last = 1'b0;
                expected_bytes.push_back(b);
            end
            held_bits  = '0;
            held_count = '0;
        end else begin
            // lengths above 16 saturate, zero length adds nothing
            len = (int'(count) > MAX_PUT_BITS) ? MAX_PUT_BITS : int'(count);
            if (len != 0) begin
                acc   = (ACC_BITS'(held_bits) << len)
                      | ACC_BITS'(int'(value) & ((1 << len) - 1));
                total = int'(held_count) + len;
                while (total >= BYTE_BITS) begin
                    total -= BYTE_BITS;
                    b.data = 8'(acc >> total);
                    b.last = 1'b0;
                    expected_bytes.push_back(b);
                end
                held_count = PCNT_BITS'(total);
                held_bits  = PEND_BITS'(acc & ((1 << total) - 1));
            end
        end
        // final byte of the item carries the last flag
        if (expected_bytes.size() > first) begin
            b = expected_bytes.pop_back();
            b.last = 1'b1;
            expected_bytes.push_back(b);
        end
    endtask

    // Output side is checked before the new item is predicted, so a byte with
    // nothing waiting is never matched against a prediction of the same edge.
    always @(posedge i_clk) begin
        t_out_byte exp_byte;
        if (!i_rst_n) begin
            held_bits  = '0;
            held_count = '0;
            fail_total = 0;
            seen_total = 0;
            expected_bytes.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                seen_total++;
                if (expected_bytes.size() == 0) begin
                    fail_total++;
                    $display("%0t: unexpected byte: expected none, actual %02h last %0b",
                             $time, i_out_byte, i_last_of_run);
                end else begin
                    exp_byte = expected_bytes.pop_front();
                    if (exp_byte.data !== i_out_byte || exp_byte.last !== i_last_of_run) begin
                        fail_total++;
                        $display("%0t: byte mismatch: expected %02h last %0b, actual %02h last %0b",
                                 $time, exp_byte.data, exp_byte.last, i_out_byte,
                                 i_last_of_run);
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                pack_item(i_mode, i_value_bits, i_bit_count);
        end
        o_fail_count <= fail_total;
        o_bytes_left <= expected_bytes.size();
        o_bytes_seen <= seen_total;
    end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import mfbp_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_ITEMS = 2000;
    localparam int PHASES       = 4;
    localparam int MAX_GAP      = 12;
    localparam int HOLD_CYCLES  = 200;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 10;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_mode;
    logic [15:0] i_value_bits;
    logic [4:0]  i_bit_count;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [7:0]  o_out_byte;
    logic        o_last_of_run;

    int fail_count;
    int bytes_left;
    int bytes_seen;
    int in_idle_pct   = 0;
    int out_stall_pct = 0;
    bit hold_req      = 1'b0;
    int items_sent    = 0;
    int flushes_sent  = 0;

    // idle percentages per phase: none, sender, receiver, both
    int phase_in_pct[PHASES]  = '{0, 56, 0, 27};
    int phase_out_pct[PHASES] = '{0, 0, 56, 27};

    msb_first_bit_packer_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_mode        (i_mode),
        .i_value_bits  (i_value_bits),
        .i_bit_count   (i_bit_count),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run)
    );

    mfbp_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_mode        (i_mode),
        .i_value_bits  (i_value_bits),
        .i_bit_count   (i_bit_count),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_out_byte    (o_out_byte),
        .i_last_of_run (o_last_of_run),
        .o_fail_count  (fail_count),
        .o_bytes_left  (bytes_left),
        .o_bytes_seen  (bytes_seen)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // receiver: random stalls, or one long hold-off on request
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else begin
                i_out_stall <= ($urandom_range(99) < out_stall_pct);
            end
        end
    end

    // watchdog: ends the run after too many cycles without any item moving
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: timeout, no item moved for %0d cycles", $time, QUIET_LIMIT);
        $display("[msb_first_bit_packer_unit] ERROR");
        $finish;
    end

    // offers one item, with a random idle gap ahead of it, until accepted
    task automatic send_item(input logic mode, input logic [15:0] value,
                             input logic [4:0] count);
        int gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < in_idle_pct)
            gap++;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_mode       <= mode;
        i_value_bits <= value;
        i_bit_count  <= count;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
        if (mode == MODE_FLUSH)
            flushes_sent++;
    endtask

    // mostly puts of 1..16 bits, some flushes, zero and oversized lengths
    task automatic random_item();
        int r = $urandom_range(99);
        logic [15:0] value = 16'($urandom);
        if (r < 12)
            send_item(MODE_FLUSH, value, 5'($urandom_range(31)));
        else if (r < 20)
            send_item(MODE_PUT, value, 5'($urandom_range(17, 31)));
        else if (r < 26)
            send_item(MODE_PUT, value, 5'd0);
        else
            send_item(MODE_PUT, value, 5'($urandom_range(1, 16)));
    endtask

    // stimulus and verdict
    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_mode       = MODE_PUT;
        i_value_bits = '0;
        i_bit_count  = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: byte-aligned puts, zero length, empty and partial flushes,
        // 23-bit fill, oversized lengths, ignored upper value bits
        send_item(MODE_PUT,   16'hFFFF, 5'd16);
        send_item(MODE_PUT,   16'h0000, 5'd16);
        send_item(MODE_PUT,   16'hFFFF, 5'd0);
        send_item(MODE_FLUSH, 16'hFFFF, 5'd31);
        send_item(MODE_PUT,   16'h0001, 5'd1);
        send_item(MODE_FLUSH, 16'h0000, 5'd0);
        send_item(MODE_PUT,   16'h007F, 5'd7);
        send_item(MODE_PUT,   16'hA5C3, 5'd16);
        send_item(MODE_FLUSH, 16'h5A5A, 5'd16);
        send_item(MODE_PUT,   16'h1234, 5'd31);
        send_item(MODE_PUT,   16'hFFFF, 5'd17);
        send_item(MODE_PUT,   16'hFFF8, 5'd3);
        send_item(MODE_PUT,   16'h001F, 5'd5);
        send_item(MODE_PUT,   16'h01FF, 5'd9);
        send_item(MODE_FLUSH, 16'h0000, 5'd0);
        send_item(MODE_FLUSH, 16'h0000, 5'd0);
        send_item(MODE_PUT,   16'h00AB, 5'd8);
        send_item(MODE_PUT,   16'h8001, 5'd16);
        send_item(MODE_PUT,   16'hFFF0, 5'd4);
        send_item(MODE_PUT,   16'h0003, 5'd2);
        send_item(MODE_FLUSH, 16'hFFFF, 5'd1);

        // random phases; the first one starts with a long output hold-off
        for (int p = 0; p < PHASES; p++) begin
            in_idle_pct   = phase_in_pct[p];
            out_stall_pct = phase_out_pct[p];
            if (p == 0)
                hold_req = 1'b1;
            repeat (RANDOM_ITEMS / PHASES) random_item();
        end

        @(negedge i_clk);
        i_in_valid    <= 1'b0;
        out_stall_pct = 0;
        while (bytes_left != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d items (%0d flushes) across four idle/stall mixes, one long hold-off",
                 items_sent, flushes_sent);
        $display("Checked %0d output bytes, %0d failures", bytes_seen, fail_count);
        if (fail_count == 0 && bytes_left == 0)
            $display("[msb_first_bit_packer_unit] OK");
        else
            $display("[msb_first_bit_packer_unit] ERROR");
        $finish;
    end

endmodule
